// File: src/udp_punch_peer_table_macros.svh
// Assertion macros for the file that carries concurrent checks.
// They expect a clock named clk and an active-low reset named arst_n in scope.
`ifndef UDP_PUNCH_PEER_TABLE_MACROS_SVH
`define UDP_PUNCH_PEER_TABLE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define UPPT_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define UPPT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: src/uppt_pkg.sv
package uppt_pkg;

	localparam int PEER_SLOTS  = 8;
	localparam int IDX_W       = (PEER_SLOTS > 1) ? $clog2(PEER_SLOTS) : 1;
	localparam int MAX_RESULTS = 8;
	localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

	localparam int ACT_W     = 3;
	localparam int ADDR_W    = 48;
	localparam int NONCE_W   = 32;
	localparam int TIME_W    = 32;
	localparam int KIND_W    = 3;
	localparam int SLOT_W    = 3;
	localparam int IVAL_W    = 16;
	localparam int ATT_W     = 8;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 16;

	localparam logic [IVAL_W-1:0] IVAL_RESET   = IVAL_W'(750);
	localparam logic [ATT_W-1:0]  MAXATT_RESET = ATT_W'(8);

	typedef enum logic [ACT_W-1:0] {
		ACT_TICK   = 3'd0,
		ACT_BEGIN  = 3'd1,
		ACT_PUNCH  = 3'd2,
		ACT_PONG   = 3'd3,
		ACT_KALIVE = 3'd4,
		ACT_CLEAR  = 3'd5
	} act_t;

	typedef enum logic [KIND_W-1:0] {
		KIND_NONE    = 3'd0,
		KIND_PUNCH   = 3'd1,
		KIND_PONG    = 3'd2,
		KIND_KALIVE  = 3'd3,
		KIND_EXPIRED = 3'd4
	} kind_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PUNCH_EN = 2'd0,
		CFG_IVAL     = 2'd1,
		CFG_MAXATT   = 2'd2,
		CFG_KA_EN    = 2'd3
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_IDLE   = 2'd0,
		ST_SWEEP  = 2'd1,
		ST_COMMIT = 2'd2,
		ST_FLUSH  = 2'd3
	} st_t;

	typedef enum logic [2:0] {
		CMD_NONE    = 3'd0,
		CMD_CLAIM   = 3'd1,
		CMD_REFRESH = 3'd2,
		CMD_ACK     = 3'd3,
		CMD_CLEAR   = 3'd4
	} cmd_op_t;

	typedef struct packed {
		logic               tick;
		logic [ADDR_W-1:0]  addr;
		logic [NONCE_W-1:0] nonce;
		logic [TIME_W-1:0]  now;
		logic               ka_en;
		logic [IVAL_W-1:0]  ival;
		logic [ATT_W-1:0]   max_att;
	} bcast_t;

	typedef struct packed {
		logic              valid;
		logic              found;
		logic [IDX_W-1:0]  fidx;
		logic              free;
		logic [IDX_W-1:0]  free_idx;
		logic [IDX_W-1:0]  best_idx;
		logic [TIME_W-1:0] best_start;
	} probe_t;

	typedef struct packed {
		cmd_op_t          op;
		logic [IDX_W-1:0] tgt;
	} cmd_t;

	typedef struct packed {
		logic               valid;
		kind_t              kind;
		logic [ADDR_W-1:0]  addr;
		logic [NONCE_W-1:0] nonce;
		logic [SLOT_W-1:0]  slot;
	} ev_t;

	typedef struct packed {
		kind_t              kind;
		logic [ADDR_W-1:0]  addr;
		logic [NONCE_W-1:0] nonce;
		logic [SLOT_W-1:0]  slot;
		logic               last;
	} res_t;

	typedef struct packed {
		logic ev_ready;
		logic fin_ready;
		logic pend_valid;
	} col_st_t;

	function automatic logic [SLOT_W-1:0] to_slot(input logic [IDX_W-1:0] idx);
		logic [SLOT_W+IDX_W-1:0] wide;
		wide = {{SLOT_W{1'b0}}, idx};
		return wide[SLOT_W-1:0];
	endfunction

endpackage

// File: src/udp_punch_peer_table.sv
// Channel   Handshake                  Payload
// item      item_valid / item_stall    action, peer_address, nonce, now_ms
// result    result_valid / result_stall kind, dest_address, packet_nonce, slot, last
// config    cfg_valid / cfg_ready      cfg_index, cfg_data
//
// A probe walks the row of slot cells one cell per cycle unless an event waits on a
// stalled output. A tick goes through a sweep and then a flush before the next item is
// taken; a begin or a received punch, pong or keepalive adds a commit after the sweep.
// A clear, an undefined action, or a tick or begin with punching off goes to the flush.
// An event or the final result that waits on a stalled output holds the item longer.
// Reset is asynchronous and active low; the table comes up empty with register defaults.
`include "udp_punch_peer_table_macros.svh"

module udp_punch_peer_table (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                item_valid,
	output logic                                item_stall,
	input  logic [uppt_pkg::ACT_W-1:0]          action,
	input  logic [uppt_pkg::ADDR_W-1:0]         peer_address,
	input  logic signed [uppt_pkg::NONCE_W-1:0] nonce,
	input  logic [uppt_pkg::TIME_W-1:0]         now_ms,
	output logic                                result_valid,
	input  logic                                result_stall,
	output logic [uppt_pkg::KIND_W-1:0]         kind,
	output logic [uppt_pkg::ADDR_W-1:0]         dest_address,
	output logic signed [uppt_pkg::NONCE_W-1:0] packet_nonce,
	output logic [uppt_pkg::SLOT_W-1:0]         slot,
	output logic                                last,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [uppt_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [uppt_pkg::CFG_DAT_W-1:0]      cfg_data
);

	uppt_pkg::st_t                 state_q;
	uppt_pkg::st_t                 state_nxt;
	uppt_pkg::act_t                act_q;
	logic [uppt_pkg::ADDR_W-1:0]   addr_q;
	logic [uppt_pkg::NONCE_W-1:0]  nonce_q;
	logic [uppt_pkg::TIME_W-1:0]   now_q;
	logic                          start_q;
	uppt_pkg::probe_t              res_q;

	logic                          en_q;
	logic [uppt_pkg::IVAL_W-1:0]   ival_q;
	logic [uppt_pkg::ATT_W-1:0]    maxatt_q;
	logic                          ka_q;

	logic                          acc;
	logic                          go_sweep;
	logic                          adv;
	logic                          fin;
	logic [uppt_pkg::IDX_W-1:0]    tgt;
	uppt_pkg::bcast_t              bc;
	uppt_pkg::cmd_t                cmd;
	uppt_pkg::ev_t                 ctrl_ev;
	uppt_pkg::ev_t                 cells_ev;
	uppt_pkg::ev_t                 col_ev;
	uppt_pkg::probe_t              prb [uppt_pkg::PEER_SLOTS+1];
	uppt_pkg::ev_t                 cev [uppt_pkg::PEER_SLOTS];
	logic [uppt_pkg::PEER_SLOTS:0] prb_vld;
	uppt_pkg::res_t                res;
	uppt_pkg::col_st_t             col_st;

	assign item_stall = (state_q != uppt_pkg::ST_IDLE);
	assign acc        = item_valid && !item_stall;
	assign cfg_ready  = 1'b1;
	assign adv        = col_st.ev_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q     <= 1'b0;
			ival_q   <= uppt_pkg::IVAL_RESET;
			maxatt_q <= uppt_pkg::MAXATT_RESET;
			ka_q     <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			case (uppt_pkg::cfg_reg_t'(cfg_index))
				uppt_pkg::CFG_PUNCH_EN: en_q     <= cfg_data[0];
				uppt_pkg::CFG_IVAL:     ival_q   <= cfg_data;
				uppt_pkg::CFG_MAXATT:   maxatt_q <= cfg_data[uppt_pkg::ATT_W-1:0];
				uppt_pkg::CFG_KA_EN:    ka_q     <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (uppt_pkg::act_t'(action))
			uppt_pkg::ACT_TICK, uppt_pkg::ACT_BEGIN: go_sweep = en_q;
			uppt_pkg::ACT_PUNCH, uppt_pkg::ACT_PONG, uppt_pkg::ACT_KALIVE: go_sweep = 1'b1;
			default: go_sweep = 1'b0;
		endcase
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			uppt_pkg::ST_IDLE: begin
				if (acc) begin
					state_nxt = go_sweep ? uppt_pkg::ST_SWEEP : uppt_pkg::ST_FLUSH;
				end
			end
			uppt_pkg::ST_SWEEP: begin
				if (prb[uppt_pkg::PEER_SLOTS].valid) begin
					state_nxt = (act_q == uppt_pkg::ACT_TICK) ?
						uppt_pkg::ST_FLUSH : uppt_pkg::ST_COMMIT;
				end
			end
			uppt_pkg::ST_COMMIT: state_nxt = uppt_pkg::ST_FLUSH;
			uppt_pkg::ST_FLUSH: begin
				if (col_st.fin_ready) begin
					state_nxt = uppt_pkg::ST_IDLE;
				end
			end
			default: state_nxt = uppt_pkg::ST_IDLE;
		endcase
	end

	assign tgt = res_q.found ? res_q.fidx : (res_q.free ? res_q.free_idx : res_q.best_idx);

	always_comb begin
		cmd       = '{op: uppt_pkg::CMD_NONE, tgt: tgt};
		ctrl_ev   = '0;
		ctrl_ev.kind  = uppt_pkg::KIND_PONG;
		ctrl_ev.addr  = addr_q;
		ctrl_ev.nonce = nonce_q;
		ctrl_ev.slot  = uppt_pkg::to_slot(tgt);
		fin       = 1'b0;
		case (state_q)
			uppt_pkg::ST_IDLE: begin
				if (acc && (uppt_pkg::act_t'(action) == uppt_pkg::ACT_CLEAR)) begin
					cmd.op = uppt_pkg::CMD_CLEAR;
				end
			end
			uppt_pkg::ST_COMMIT: begin
				case (act_q)
					uppt_pkg::ACT_BEGIN: begin
						cmd.op = res_q.found ? uppt_pkg::CMD_REFRESH : uppt_pkg::CMD_CLAIM;
					end
					uppt_pkg::ACT_PUNCH: begin
						cmd.op        = res_q.found ? uppt_pkg::CMD_REFRESH : uppt_pkg::CMD_CLAIM;
						ctrl_ev.valid = 1'b1;
					end
					uppt_pkg::ACT_PONG: begin
						cmd.op = res_q.found ? uppt_pkg::CMD_ACK : uppt_pkg::CMD_NONE;
					end
					uppt_pkg::ACT_KALIVE: begin
						cmd.op        = res_q.found ? uppt_pkg::CMD_ACK : uppt_pkg::CMD_NONE;
						ctrl_ev.valid = res_q.found;
					end
					default: ;
				endcase
			end
			uppt_pkg::ST_FLUSH: fin = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= uppt_pkg::ST_IDLE;
			start_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (acc && go_sweep) begin
				start_q <= 1'b1;
			end else if (adv) begin
				start_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			act_q   <= uppt_pkg::act_t'(action);
			addr_q  <= peer_address;
			nonce_q <= $unsigned(nonce);
			now_q   <= now_ms;
		end
		if ((state_q == uppt_pkg::ST_SWEEP) && prb[uppt_pkg::PEER_SLOTS].valid) begin
			res_q <= prb[uppt_pkg::PEER_SLOTS];
		end
	end

	assign bc = '{tick: (act_q == uppt_pkg::ACT_TICK), addr: addr_q, nonce: nonce_q,
		now: now_q, ka_en: ka_q, ival: ival_q, max_att: maxatt_q};

	always_comb begin
		prb[0]       = '0;
		prb[0].valid = start_q;
	end

	for (genvar g = 0; g < uppt_pkg::PEER_SLOTS; g++) begin : g_cell
		uppt_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.cell_idx (uppt_pkg::IDX_W'(g)),
			.bc       (bc),
			.cmd      (cmd),
			.adv      (adv),
			.prb_in   (prb[g]),
			.prb_out  (prb[g+1]),
			.ev       (cev[g])
		);
	end

	always_comb begin
		cells_ev = '0;
		for (int i = 0; i < uppt_pkg::PEER_SLOTS; i++) begin
			cells_ev = cells_ev | cev[i];
		end
	end

	always_comb begin
		for (int i = 0; i <= uppt_pkg::PEER_SLOTS; i++) begin
			prb_vld[i] = prb[i].valid;
		end
	end

	assign col_ev = (state_q == uppt_pkg::ST_COMMIT) ? ctrl_ev : cells_ev;

	uppt_collect u_collect (
		.clk       (clk),
		.arst_n    (arst_n),
		.ev        (col_ev),
		.fin       (fin),
		.stall     (result_stall),
		.res_valid (result_valid),
		.res       (res),
		.st        (col_st)
	);

	assign kind         = res.kind;
	assign dest_address = res.addr;
	assign packet_nonce = $signed(res.nonce);
	assign slot         = res.slot;
	assign last         = res.last;

	`UPPT_ASSERT_NOW(a_single_probe, 1'b1, $onehot0(prb_vld), "more than one probe in the cell row")
	`UPPT_ASSERT_NOW(a_idle_drained, state_q == uppt_pkg::ST_IDLE, !(|prb_vld) && !col_st.pend_valid, "idle with work still in flight")
	`UPPT_ASSERT_NEXT(a_flush_last, (state_q == uppt_pkg::ST_FLUSH) && col_st.fin_ready, result_valid && last, "finished item without a final result")

endmodule

// File: src/uppt_cell.sv
module uppt_cell (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic [uppt_pkg::IDX_W-1:0] cell_idx,
	input  uppt_pkg::bcast_t       bc,
	input  uppt_pkg::cmd_t         cmd,
	input  logic                   adv,
	input  uppt_pkg::probe_t       prb_in,
	output uppt_pkg::probe_t       prb_out,
	output uppt_pkg::ev_t          ev
);

	logic                           active_q;
	logic                           acked_q;
	logic [uppt_pkg::ADDR_W-1:0]    addr_q;
	logic [uppt_pkg::NONCE_W-1:0]   nonce_q;
	logic [uppt_pkg::TIME_W-1:0]    start_q;
	logic [uppt_pkg::TIME_W-1:0]    last_q;
	logic [uppt_pkg::ATT_W-1:0]     att_q;
	uppt_pkg::probe_t               prb_q;
	uppt_pkg::probe_t               prb_nxt;

	logic                           here;
	logic                           match;
	logic [uppt_pkg::TIME_W-1:0]    diff;
	logic                           ka_due;
	logic                           pu_due;
	logic                           expire;
	logic                           do_ka;
	logic                           do_exp;
	logic                           do_punch;
	logic                           sel;

	assign here  = prb_in.valid;
	assign match = active_q && (addr_q == bc.addr);
	assign diff  = bc.now - last_q;

	assign ka_due = bc.ka_en &&
		($signed(diff) >= $signed({14'd0, bc.ival, 2'b00}));
	assign pu_due = (last_q == '0) || ($signed(diff) >= $signed({16'd0, bc.ival}));
	assign expire = (att_q >= bc.max_att);

	assign do_ka    = here && bc.tick && active_q && acked_q && ka_due;
	assign do_exp   = here && bc.tick && active_q && !acked_q && expire;
	assign do_punch = here && bc.tick && active_q && !acked_q && !expire && pu_due;

	assign sel = (cmd.tgt == cell_idx);

	// Fields stay zero unless this cell reports, as the row's events are ORed together.
	always_comb begin
		ev       = '0;
		ev.kind  = uppt_pkg::KIND_NONE;
		ev.valid = do_ka || do_exp || do_punch;
		if (do_ka) begin
			ev.kind  = uppt_pkg::KIND_KALIVE;
			ev.addr  = addr_q;
			ev.slot  = uppt_pkg::to_slot(cell_idx);
			ev.nonce = nonce_q;
		end else if (do_exp) begin
			ev.kind  = uppt_pkg::KIND_EXPIRED;
			ev.addr  = addr_q;
			ev.slot  = uppt_pkg::to_slot(cell_idx);
			ev.nonce = '0;
		end else if (do_punch) begin
			ev.kind  = uppt_pkg::KIND_PUNCH;
			ev.addr  = addr_q;
			ev.slot  = uppt_pkg::to_slot(cell_idx);
			ev.nonce = nonce_q;
		end
	end

	always_comb begin
		prb_nxt = prb_in;
		if (!prb_in.found && match) begin
			prb_nxt.found = 1'b1;
			prb_nxt.fidx  = cell_idx;
		end
		if (!prb_in.free) begin
			if (!active_q) begin
				prb_nxt.free     = 1'b1;
				prb_nxt.free_idx = cell_idx;
			end else if ((cell_idx == '0) ||
				($signed(start_q) < $signed(prb_in.best_start))) begin
				prb_nxt.best_idx   = cell_idx;
				prb_nxt.best_start = start_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prb_q <= '0;
		end else if (adv) begin
			prb_q <= prb_nxt;
		end
	end

	assign prb_out = prb_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			acked_q  <= 1'b0;
		end else if (cmd.op == uppt_pkg::CMD_CLEAR) begin
			active_q <= 1'b0;
			acked_q  <= 1'b0;
		end else if (sel && (cmd.op == uppt_pkg::CMD_CLAIM)) begin
			active_q <= 1'b1;
			acked_q  <= 1'b0;
		end else if (sel && (cmd.op == uppt_pkg::CMD_REFRESH)) begin
			acked_q <= 1'b0;
		end else if (sel && (cmd.op == uppt_pkg::CMD_ACK)) begin
			acked_q <= 1'b1;
		end else if (adv && do_exp) begin
			active_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (sel && (cmd.op == uppt_pkg::CMD_CLAIM)) begin
			addr_q  <= bc.addr;
			nonce_q <= bc.nonce;
			start_q <= bc.now;
			last_q  <= '0;
			att_q   <= '0;
		end else if (sel && (cmd.op == uppt_pkg::CMD_REFRESH)) begin
			if (bc.nonce != '0) begin
				nonce_q <= bc.nonce;
			end
			last_q <= '0;
			att_q  <= '0;
		end else if (adv && do_ka) begin
			last_q <= bc.now;
		end else if (adv && do_punch) begin
			last_q <= bc.now;
			att_q  <= att_q + 1'b1;
		end
	end

endmodule

// File: src/uppt_collect.sv
module uppt_collect (
	input  logic               clk,
	input  logic               arst_n,
	input  uppt_pkg::ev_t      ev,
	input  logic               fin,
	input  logic               stall,
	output logic               res_valid,
	output uppt_pkg::res_t     res,
	output uppt_pkg::col_st_t  st
);

	uppt_pkg::ev_t                 pend_q;
	logic                          pend_vld_q;
	logic [uppt_pkg::CNT_W-1:0]    cnt_q;
	uppt_pkg::res_t                out_q;
	logic                          out_vld_q;

	logic                          out_free;
	logic                          push;
	logic                          ev_ready;
	logic                          shift_out;
	logic                          fin_out;

	assign out_free  = !out_vld_q || !stall;
	assign push      = ev.valid && (cnt_q < uppt_pkg::CNT_W'(uppt_pkg::MAX_RESULTS));
	assign ev_ready  = !(push && pend_vld_q && !out_free);
	assign shift_out = push && ev_ready && pend_vld_q;
	assign fin_out   = fin && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			pend_vld_q <= 1'b0;
			cnt_q      <= '0;
		end else begin
			if (shift_out || fin_out) begin
				out_vld_q <= 1'b1;
			end else if (!stall) begin
				out_vld_q <= 1'b0;
			end
			if (fin_out) begin
				pend_vld_q <= 1'b0;
				cnt_q      <= '0;
			end else if (push && ev_ready) begin
				pend_vld_q <= 1'b1;
				cnt_q      <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push && ev_ready) begin
			pend_q <= ev;
		end
		if (shift_out) begin
			out_q <= '{kind: pend_q.kind, addr: pend_q.addr, nonce: pend_q.nonce,
				slot: pend_q.slot, last: 1'b0};
		end else if (fin_out) begin
			if (pend_vld_q) begin
				out_q <= '{kind: pend_q.kind, addr: pend_q.addr, nonce: pend_q.nonce,
					slot: pend_q.slot, last: 1'b1};
			end else begin
				out_q <= '{kind: uppt_pkg::KIND_NONE, addr: '0, nonce: '0,
					slot: '0, last: 1'b1};
			end
		end
	end

	assign res_valid     = out_vld_q;
	assign res           = out_q;
	assign st.ev_ready   = ev_ready;
	assign st.fin_ready  = out_free;
	assign st.pend_valid = pend_vld_q;

endmodule
